### rtl/arpg_pkg.sv
// Shared constants and types for the axis ramp position generator.
// No dependencies.
`default_nettype none
package arpg_pkg;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam logic [13:0] POS_MAX           = 14'd9999;
  localparam logic [23:0] AMOUNT_MAX        = 24'd9999999;
  localparam logic [6:0]  SPEED_SCALE       = 7'd100;
  localparam logic [13:0] HOME_RESET        = 14'd5000;

  localparam logic [1:0] FUNC_SET   = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CHECK = 2'd3;

  localparam logic [1:0] KIND_SPEED    = 2'd0;
  localparam logic [1:0] KIND_INTERVAL = 2'd1;

  localparam logic [1:0] EASE_LINEAR = 2'd0;
  localparam logic [1:0] EASE_IN     = 2'd1;
  localparam logic [1:0] EASE_OUT    = 2'd2;
  localparam logic [1:0] EASE_INOUT  = 2'd3;

  localparam logic CFG_EASING = 1'b0;
  localparam logic CFG_HOME   = 1'b1;

  typedef struct packed {
    logic        start;
    logic [13:0] start_pos;
    logic [13:0] stop_pos;
    logic [31:0] start_time;
    logic [31:0] stop_time;
    logic [31:0] t;
    logic [1:0]  mode;
  } arpg_eval_req_t;
endpackage
`default_nettype wire

### rtl/axis_ramp_position_generator.sv
// Top level of the axis ramp position generator.
// Depends on arpg_pkg and arpg_divider.
`default_nettype none
// One item is taken at a time. The position is evaluated by a sequencer that
// drives one divider (one quotient bit per cycle) and one multiplier, with a
// register after every product. An evaluation inside the ramp runs the division
// (NW quotient bits, NW being the larger of 46 and 33+FRACTION_BITS, so 49 by default)
// and then up to six multiply and output steps; outside the ramp it needs neither.
// A read or check evaluates once. A set target or stop evaluates, updates the
// ramp and evaluates again; a set target in speed mode with a nonzero amount
// puts one more division between the two. The result waits in an output
// register; the next item is taken once it leaves.
module axis_ramp_position_generator #(
  parameter int unsigned FRACTION_BITS = arpg_pkg::FRACTION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_time_ms,
  input  wire logic [13:0] in_target,
  input  wire logic [1:0]  in_move_kind,
  input  wire logic [23:0] in_amount,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_position,
  output logic             out_moved,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [13:0] cfg_data
);
  import arpg_pkg::*;
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned NW = (33 + FB > 46) ? 33 + FB : 46;
  localparam int unsigned MW = (FB + 1 > 14) ? FB + 1 : 14;
  localparam logic [FB:0] ONE  = (FB+1)'(1) << FB;
  localparam logic [FB:0] HALF = (FB+1)'(1) << (FB - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EV0   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_M3    = 4'd5;
  localparam logic [3:0] S_M4    = 4'd6;
  localparam logic [3:0] S_M5    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_SDIV  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic        pass_r, pass_nxt;   // 0: first evaluation, 1: final evaluation
  logic        sdiv_r, sdiv_nxt;   // speed division already done
  logic [1:0]  mode_r;
  logic [13:0] spos_r, spos_nxt, epos_r, epos_nxt, chk_r, chk_nxt;
  logic [31:0] stime_r, stime_nxt, etime_r, etime_nxt;
  logic [1:0]  func_r, kind_r;
  logic [31:0] t_r;
  logic [13:0] x_r;
  logic [23:0] y_r;
  logic [13:0] pos_r, pos_nxt;
  logic        moved_r, moved_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [FB:0] f_r, f_nxt, a_r, a_nxt, b_r, b_nxt, e_r, e_nxt;
  logic [2*MW-1:0] p_r, p_nxt;

  // Evaluation window quantities.
  logic        not_started, after;
  logic [31:0] span, el;
  logic        neg;
  logic [13:0] mag_d;
  logic [13:0] clamped_x;
  logic [23:0] clamped_y;
  logic [13:0] home_wr;

  logic          div_start;
  logic [NW-1:0] div_numer;
  logic [31:0]   div_denom;
  logic          div_done;
  logic [NW-1:0] div_quot;

  arpg_divider #(.NW(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .numer(div_numer),
    .denom(div_denom), .done(div_done), .quot(div_quot)
  );

  assign after       = t_r > etime_r;
  assign not_started = !(t_r > stime_r);
  assign span   = etime_r - stime_r;
  assign el     = t_r - stime_r;
  assign neg    = epos_r < spos_r;
  assign mag_d  = neg ? spos_r - epos_r : epos_r - spos_r;
  assign clamped_x = (in_target > POS_MAX) ? POS_MAX : in_target;
  assign clamped_y = (in_amount > AMOUNT_MAX) ? AMOUNT_MAX : in_amount;
  assign home_wr   = (cfg_data > POS_MAX) ? POS_MAX : cfg_data;

  // Shared multiplier with a registered product.
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  function automatic logic [FB:0] rnd(input logic [2*MW-1:0] v);
    logic [2*MW-1:0] s;
    s = v + (2*MW)'(HALF);
    return s[2*FB:FB];
  endfunction

  function automatic logic [13:0] clamp14(input logic [47:0] v);
    return (v > 48'(POS_MAX)) ? POS_MAX : v[13:0];
  endfunction

  logic [47:0] ediff, base, sum;
  logic [FB:0] e_cl;
  assign e_cl  = (e_r > ONE) ? ONE : e_r;
  assign ediff = 48'(p_r);
  assign base  = (48'(spos_r) << FB) + 48'(HALF);
  assign sum   = neg ? base - ediff : base + ediff;

  always_comb begin
    state_nxt = state_r; pass_nxt = pass_r; sdiv_nxt = sdiv_r;
    spos_nxt = spos_r; epos_nxt = epos_r; stime_nxt = stime_r; etime_nxt = etime_r;
    chk_nxt = chk_r; pos_nxt = pos_r; moved_nxt = moved_r; ovalid_nxt = ovalid_r;
    f_nxt = f_r; a_nxt = a_r; b_nxt = b_r; e_nxt = e_r; p_nxt = p_r;
    div_start = 1'b0; div_numer = '0; div_denom = span;
    mul_a = '0; mul_b = '0;
    if (out_valid && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = S_EV0; pass_nxt = 1'b0; sdiv_nxt = 1'b0; moved_nxt = 1'b0;
        end
      end
      S_EV0: begin
        if (after) begin
          pos_nxt = clamp14(48'(epos_r)); state_nxt = S_FIN;
        end else if (not_started) begin
          pos_nxt = clamp14(48'(spos_r)); state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          if (mode_r == EASE_LINEAR) div_numer = NW'(el) * NW'(mag_d);
          else div_numer = (NW'(el) << FB) + NW'(span >> 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (mode_r == EASE_LINEAR) begin
            if (neg) begin
              pos_nxt = clamp14(48'(spos_r) - 48'(div_quot));
              if (48'(div_quot) > 48'(spos_r)) pos_nxt = '0;
            end else begin
              pos_nxt = clamp14(48'(spos_r) + 48'(div_quot));
            end
            state_nxt = S_FIN;
          end else begin
            f_nxt = (div_quot > NW'(ONE)) ? ONE : div_quot[FB:0];
            state_nxt = S_M1;
          end
        end
      end
      S_M1: begin  // a = round(f*f)
        mul_a = MW'(f_r); mul_b = MW'(f_r); a_nxt = rnd(mul_p); state_nxt = S_M2;
      end
      S_M2: begin  // b = 1 - round(g*g)
        mul_a = MW'(ONE - f_r); mul_b = MW'(ONE - f_r); b_nxt = ONE - rnd(mul_p);
        if (mode_r == EASE_IN) begin
          e_nxt = a_r; state_nxt = S_M5;
        end else if (mode_r == EASE_OUT) begin
          e_nxt = ONE - rnd(mul_p); state_nxt = S_M5;
        end else state_nxt = S_M3;
      end
      S_M3: begin
        mul_a = MW'(ONE - f_r); mul_b = MW'(a_r); p_nxt = mul_p; state_nxt = S_M4;
      end
      S_M4: begin
        mul_a = MW'(f_r); mul_b = MW'(b_r);
        e_nxt = rnd(p_r + mul_p);
        state_nxt = S_M5;
      end
      S_M5: begin  // e * |diff|
        mul_a = MW'(e_cl); mul_b = MW'(mag_d);
        p_nxt = mul_p;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (neg && (ediff > base)) pos_nxt = '0;
        else pos_nxt = clamp14(sum >> FB);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!pass_r) begin
          pass_nxt = 1'b1;
          case (func_r)
            FUNC_SET: begin
              if (kind_r == KIND_SPEED) begin
                if (!sdiv_r) begin
                  spos_nxt = pos_r;
                  if (y_r == '0) begin
                    etime_nxt = t_r; stime_nxt = t_r; epos_nxt = x_r;
                    state_nxt = S_EV0;
                  end else state_nxt = S_SDIV;
                end
              end else begin
                if (kind_r == KIND_INTERVAL) begin
                  spos_nxt = pos_r; etime_nxt = t_r + 32'(y_r);
                end else if (y_r == '0) begin
                  etime_nxt = t_r; spos_nxt = x_r;
                end
                stime_nxt = t_r; epos_nxt = x_r; state_nxt = S_EV0;
              end
            end
            FUNC_STOP: begin
              spos_nxt = pos_r; epos_nxt = pos_r; stime_nxt = t_r; etime_nxt = t_r;
              state_nxt = S_EV0;
            end
            // The ramp is unchanged, so the first evaluation is the result.
            FUNC_CHECK: begin
              if (pos_r != chk_r) begin
                chk_nxt = pos_r; moved_nxt = 1'b1;
              end
              state_nxt = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end else if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_SDIV: begin
        if (!sdiv_r) begin
          div_start = 1'b1; sdiv_nxt = 1'b1;
          div_numer = NW'((x_r > spos_r ? x_r - spos_r : spos_r - x_r)) * NW'(SPEED_SCALE);
          div_denom = 32'(y_r);
        end else if (div_done) begin
          etime_nxt = t_r + div_quot[31:0]; stime_nxt = t_r; epos_nxt = x_r;
          state_nxt = S_EV0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // A home write puts the ramp at rest there, as after reset.
    if (cfg_we && cfg_index == CFG_HOME) begin
      spos_nxt = home_wr; epos_nxt = home_wr; stime_nxt = '0;
      etime_nxt = 32'(home_wr);
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt; a_r <= a_nxt; b_r <= b_nxt; e_r <= e_nxt; p_r <= p_nxt;
    pos_r <= pos_nxt;
    if (in_valid && in_ready) begin
      func_r <= in_func; t_r <= in_time_ms; x_r <= clamped_x;
      kind_r <= in_move_kind; y_r <= clamped_y;
    end
    if (!rst_n) begin
      state_r <= S_IDLE; pass_r <= 1'b0; sdiv_r <= 1'b0; ovalid_r <= 1'b0;
      moved_r <= 1'b0; mode_r <= EASE_LINEAR;
      spos_r <= HOME_RESET; epos_r <= HOME_RESET; stime_r <= '0;
      etime_r <= 32'(HOME_RESET); chk_r <= '0;
    end else begin
      state_r <= state_nxt; pass_r <= pass_nxt; sdiv_r <= sdiv_nxt;
      ovalid_r <= ovalid_nxt; moved_r <= moved_nxt; chk_r <= chk_nxt;
      spos_r <= spos_nxt; epos_r <= epos_nxt; stime_r <= stime_nxt;
      etime_r <= etime_nxt;
      if (cfg_we && cfg_index == CFG_EASING) mode_r <= cfg_data[1:0];
    end
  end

  assign in_ready     = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid    = ovalid_r;
  assign out_position = pos_r;
  assign out_moved    = moved_r;

  // A result never reports a position outside the legal range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= POS_MAX) else $error("position out of range");
  // No new item is taken while a result is still held.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item accepted over pending result");
  // Moved is only reported for a check command.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_moved) |-> func_r == FUNC_CHECK) else $error("moved on non-check");
endmodule
`default_nettype wire

### rtl/arpg_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on arpg_pkg.
`default_nettype none
module arpg_divider #(
  parameter int unsigned NW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] numer,
  input  wire logic [31:0]   denom,
  output logic               done,
  output logic [NW-1:0]      quot
);
  import arpg_pkg::*;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0]   shifted;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    shifted = {rem_r[31:0], q_r[NW-1]};
    if (start) begin
      q_nxt = numer; rem_nxt = '0; den_nxt = denom;
      cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire
